### rtl/ilv_pkg.sv
// ----------------------------------------------------------------------------
// ilv_pkg
// Shared types and constants for the integer literal converter: request and
// result payloads, scan phase and radix codes, and the character codes used
// by the prefix and digit logic.
// ----------------------------------------------------------------------------
package ilv_pkg;

  // Default width of the signed value range (the largest value is 2^(n-1)-1).
  localparam int unsigned VALUE_BITS_DEF = 64;

  // Fixed width of the value field on the result channel.
  localparam int unsigned VALUE_W = 63;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
  localparam logic [7:0] CH_USCORE = 8'h5F; // '_'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LB    = 8'h62;  // 'b'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [7:0] CH_LX    = 8'h78;  // 'x'

  // Scan phase of the literal.
  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,  // first character expected
    PH_ZERO  = 2'd1,  // a leading '0' has been seen
    PH_CONV  = 2'd2,  // converting digits
    PH_STOP  = 2'd3   // conversion stopped, waiting for the last character
  } phase_t;

  // Number base.
  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_OCT = 2'd2,
    RX_BIN = 2'd3
  } radix_t;

  // One character request.
  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_req_t;

  // One conversion result.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               overflowed;
  } out_res_t;

  // Character classification for the current base.
  typedef struct packed {
    logic       is_skip;   // underscore separator
    logic       is_digit;  // valid digit of the base
    logic [3:0] digit;     // digit value when is_digit is set
  } digit_info_t;

endpackage

### rtl/ilv_digit.sv
// ----------------------------------------------------------------------------
// ilv_digit
// Classifies one character against a number base: separator, digit with its
// value, or a character that ends the conversion.
// ----------------------------------------------------------------------------
module ilv_digit (
  input  logic [7:0]           char_in,
  input  ilv_pkg::radix_t      radix,
  output ilv_pkg::digit_info_t info
);

  logic       is_dec;
  logic       is_lhex;
  logic       is_uhex;
  logic [7:0] dec_off;
  logic [7:0] lhex_off;
  logic [7:0] uhex_off;

  // Range checks and offsets used by the digit selection below.
  always_comb begin
    is_dec   = (char_in >= ilv_pkg::CH_ZERO) && (char_in <= ilv_pkg::CH_NINE);
    is_lhex  = (char_in >= ilv_pkg::CH_LA) && (char_in <= ilv_pkg::CH_LF);
    is_uhex  = (char_in >= ilv_pkg::CH_UA) && (char_in <= ilv_pkg::CH_UF);
    dec_off  = char_in - ilv_pkg::CH_ZERO;
    lhex_off = char_in - ilv_pkg::CH_LA + 8'd10;
    uhex_off = char_in - ilv_pkg::CH_UA + 8'd10;
  end

  // Digit value for the selected base.
  always_comb begin
    info.is_skip  = (char_in == ilv_pkg::CH_USCORE);
    info.is_digit = 1'b0;
    info.digit    = dec_off[3:0];
    case (radix)
      ilv_pkg::RX_HEX: begin
        if (is_dec) begin
          info.is_digit = 1'b1;
        end else if (is_lhex) begin
          info.is_digit = 1'b1;
          info.digit    = lhex_off[3:0];
        end else if (is_uhex) begin
          info.is_digit = 1'b1;
          info.digit    = uhex_off[3:0];
        end
      end
      ilv_pkg::RX_OCT: begin
        info.is_digit = (char_in >= ilv_pkg::CH_ZERO) && (char_in <= ilv_pkg::CH_SEVEN);
      end
      ilv_pkg::RX_BIN: begin
        info.is_digit = (char_in == ilv_pkg::CH_ZERO) || (char_in == ilv_pkg::CH_ONE);
      end
      default: begin
        info.is_digit = is_dec;
      end
    endcase
  end

endmodule

### rtl/ilv_core.sv
// ----------------------------------------------------------------------------
// ilv_core
// Scan state of the literal: prefix detection, base selection, and the
// multiply-add of each digit with an exact overflow check. Gives the result
// that the current character would produce if it were the last one.
// ----------------------------------------------------------------------------
module ilv_core #(
  parameter int unsigned VALUE_BITS = ilv_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        char_in,
  input  logic              last_char,
  output ilv_pkg::out_res_t res
);

  localparam int unsigned AW = VALUE_BITS - 1;  // accumulator never exceeds 2^AW-1
  localparam int unsigned PW = AW + 4;          // room for acc*16 + 15

  ilv_pkg::phase_t      phase_r, phase_nxt;
  ilv_pkg::phase_t      phase_pre;
  ilv_pkg::radix_t      radix_r, radix_nxt;
  ilv_pkg::radix_t      eff_rx;
  logic [AW-1:0]        acc_r, acc_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 do_conv;
  logic [PW-1:0]        acc_ext;
  logic [PW-1:0]        scaled;
  logic                 over;
  ilv_pkg::digit_info_t dig;

  ilv_digit u_digit (
    .char_in (char_in),
    .radix   (eff_rx),
    .info    (dig)
  );

  // Prefix handling: pick the base in force for this character and whether
  // the character goes to the converter.
  always_comb begin
    eff_rx    = radix_r;
    do_conv   = 1'b0;
    phase_pre = phase_r;
    case (phase_r)
      ilv_pkg::PH_FIRST: begin
        eff_rx = ilv_pkg::RX_DEC;
        if (char_in == ilv_pkg::CH_ZERO) begin
          phase_pre = ilv_pkg::PH_ZERO;
        end else begin
          phase_pre = ilv_pkg::PH_CONV;
          do_conv   = 1'b1;
        end
      end
      ilv_pkg::PH_ZERO: begin
        phase_pre = ilv_pkg::PH_CONV;
        if ((char_in == ilv_pkg::CH_LX) || (char_in == ilv_pkg::CH_UX)) begin
          eff_rx = ilv_pkg::RX_HEX;
        end else if (char_in == ilv_pkg::CH_LB) begin
          eff_rx = ilv_pkg::RX_BIN;
        end else if ((char_in >= ilv_pkg::CH_ZERO) && (char_in <= ilv_pkg::CH_SEVEN)) begin
          eff_rx  = ilv_pkg::RX_OCT;
          do_conv = 1'b1;
        end else begin
          eff_rx  = ilv_pkg::RX_DEC;
          do_conv = 1'b1;
        end
      end
      ilv_pkg::PH_CONV: begin
        do_conv = 1'b1;
      end
      default: begin
        do_conv = 1'b0;
      end
    endcase
  end

  // Multiply by the base with shifts, add the digit, and compare against the
  // largest signed value.
  always_comb begin
    acc_ext = PW'(acc_r);
    case (eff_rx)
      ilv_pkg::RX_HEX: scaled = acc_ext << 4;
      ilv_pkg::RX_OCT: scaled = acc_ext << 3;
      ilv_pkg::RX_BIN: scaled = acc_ext << 1;
      default:         scaled = (acc_ext << 3) + (acc_ext << 1);
    endcase
    scaled = scaled + PW'(dig.digit);
    over   = scaled > {4'b0000, {AW{1'b1}}};
  end

  // Next phase, accumulator and overflow flag.
  always_comb begin
    phase_nxt = phase_pre;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    radix_nxt = eff_rx;
    if (do_conv && !dig.is_skip) begin
      if (!dig.is_digit) begin
        phase_nxt = ilv_pkg::PH_STOP;
      end else if (over) begin
        acc_nxt   = '0;
        ovf_nxt   = 1'b1;
        phase_nxt = ilv_pkg::PH_STOP;
      end else begin
        acc_nxt = scaled[AW-1:0];
      end
    end
    res.overflowed = ovf_nxt;
    res.value      = ovf_nxt ? '0 : ilv_pkg::VALUE_W'(acc_nxt);
  end

  // State registers; the last character returns the scan to its start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ilv_pkg::PH_FIRST;
      radix_r <= ilv_pkg::RX_DEC;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (step) begin
      if (last_char) begin
        phase_r <= ilv_pkg::PH_FIRST;
        radix_r <= ilv_pkg::RX_DEC;
        acc_r   <= '0;
        ovf_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        radix_r <= radix_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

endmodule

### rtl/integer_literal_to_value.sv
// ----------------------------------------------------------------------------
// integer_literal_to_value
// Converts an integer literal, one character per request, into its value.
// "0x"/"0X" selects hex, "0b" binary, a leading '0' then 0-7 octal, else
// decimal. Underscores are skipped; a value beyond the signed maximum gives 0
// with the overflow flag set. One result is given per request marked last.
//
//   channel | direction | payload   | handshake
//   --------+-----------+-----------+------------------------------
//   in_     | input     | in_req_t  | in_valid / in_stall
//   out_    | output    | out_res_t | out_valid / out_stall
//
// One character request is taken every cycle while in_stall is low. A request
// is held in the input register, then updates the scan state, and a last
// request loads the result register as it does so. Reset returns the scan to
// the first character and empties both registers. in_stall rises only while a
// last request waits behind a held result; other requests pass regardless of
// out_stall.
// ----------------------------------------------------------------------------
module integer_literal_to_value #(
  parameter int unsigned VALUE_BITS = ilv_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ilv_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output ilv_pkg::out_res_t out_res
);

  logic              req_valid_r;
  ilv_pkg::in_req_t  req_r;
  logic              res_valid_r;
  ilv_pkg::out_res_t res_r;
  ilv_pkg::out_res_t res_nxt;
  logic              res_free;
  logic              step;

  // Flow control: a non-last request always moves on, a last one needs room.
  always_comb begin
    res_free = !res_valid_r || !out_stall;
    step     = req_valid_r && (!req_r.last_char || res_free);
    in_stall = req_valid_r && !step;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r <= in_req;
    end
  end

  ilv_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .char_in   (req_r.char_in),
    .last_char (req_r.last_char),
    .res       (res_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_free) begin
      res_valid_r <= step && req_r.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && step && req_r.last_char) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_res   = res_r;

endmodule

### rtl/ilv_checker.sv
// ----------------------------------------------------------------------------
// ilv_checker
// Port-level checks for the integer literal converter, bound to the top level.
// ----------------------------------------------------------------------------
module ilv_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input ilv_pkg::in_req_t  in_req,
  input logic              out_valid,
  input logic              out_stall,
  input ilv_pkg::out_res_t out_res
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

  // An overflowed result carries a zero value.
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.overflowed |-> out_res.value == '0)
    else $error("overflow result with nonzero value");

  // A new result must stem from an accepted last request.
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_req.last_char, 2))
    else $error("result without a last request");

  // The input only backs up behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

endmodule

bind integer_literal_to_value ilv_checker u_ilv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for integer_literal_to_value. Literals are built
// as character requests in a queue, sent by a bursty driver, and predicted
// one character at a time by a scan model kept inside the testbench. A
// monitor behind a patterned stall compares every result, field by field,
// with the oldest predicted value.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [63:0] SIGNED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [7:0]  NUL_CH     = 8'h00;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          RANDOM_ITEMS = 400;

  localparam string DEC_DIGITS = "0123456789";
  localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
  localparam string OCT_DIGITS = "01234567";
  localparam string BIN_DIGITS = "01";

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  ilv_pkg::in_req_t  in_req    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  ilv_pkg::out_res_t out_res;

  // Pending character requests, the literal under construction, and the
  // values predicted for literals already sent.
  ilv_pkg::in_req_t  char_q[$];
  logic [7:0]        lit_q[$];
  ilv_pkg::out_res_t value_q[$];

  // Scan model state.
  ilv_pkg::phase_t scan_ph  = ilv_pkg::PH_FIRST;
  ilv_pkg::radix_t scan_rx  = ilv_pkg::RX_DEC;
  logic [63:0]     scan_acc = '0;
  logic            scan_ovf = 1'b0;

  int err_cnt    = 0;
  int cyc_cnt    = 0;
  int burst_left = 1;
  int gap_left   = 0;
  int stall_mode = 0;
  int mode_left  = 0;
  ilv_pkg::out_res_t want_res;

  integer_literal_to_value u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  always #6 clk = ~clk;

  // Digit value of a character in the given base, or -1 when it is not one.
  function automatic int digit_val(logic [7:0] c, ilv_pkg::radix_t r);
    case (r)
      ilv_pkg::RX_HEX: begin
        if (c >= ilv_pkg::CH_ZERO && c <= ilv_pkg::CH_NINE) return int'(c - ilv_pkg::CH_ZERO);
        if (c >= ilv_pkg::CH_LA && c <= ilv_pkg::CH_LF) return int'(c - ilv_pkg::CH_LA) + 10;
        if (c >= ilv_pkg::CH_UA && c <= ilv_pkg::CH_UF) return int'(c - ilv_pkg::CH_UA) + 10;
        return -1;
      end
      ilv_pkg::RX_OCT: begin
        if (c >= ilv_pkg::CH_ZERO && c <= ilv_pkg::CH_SEVEN) return int'(c - ilv_pkg::CH_ZERO);
        return -1;
      end
      ilv_pkg::RX_BIN: begin
        if (c == ilv_pkg::CH_ZERO || c == ilv_pkg::CH_ONE) return int'(c - ilv_pkg::CH_ZERO);
        return -1;
      end
      default: begin
        if (c >= ilv_pkg::CH_ZERO && c <= ilv_pkg::CH_NINE) return int'(c - ilv_pkg::CH_ZERO);
        return -1;
      end
    endcase
  endfunction

  function automatic logic [63:0] base_val(ilv_pkg::radix_t r);
    case (r)
      ilv_pkg::RX_HEX: return 64'd16;
      ilv_pkg::RX_OCT: return 64'd8;
      ilv_pkg::RX_BIN: return 64'd2;
      default:         return 64'd10;
    endcase
  endfunction

  // Accumulate one character while converting. Overflow is caught before the
  // multiply-add, so the accumulator never wraps.
  task automatic take_digit(input logic [7:0] c);
    int          d;
    logic [63:0] b;
    logic [63:0] lim;
    if (c == ilv_pkg::CH_USCORE) return;
    d = digit_val(c, scan_rx);
    if (d < 0) begin
      scan_ph = ilv_pkg::PH_STOP;
      return;
    end
    b   = base_val(scan_rx);
    lim = (SIGNED_MAX - 64'(d)) / b;
    if (scan_acc > lim) begin
      scan_acc = '0;
      scan_ovf = 1'b1;
      scan_ph  = ilv_pkg::PH_STOP;
    end else begin
      scan_acc = scan_acc * b + 64'(d);
    end
  endtask

  // Advance the scan model by one accepted request; a last request yields
  // the predicted value and restarts the scan.
  task automatic scan_char(input ilv_pkg::in_req_t r);
    ilv_pkg::out_res_t res;
    case (scan_ph)
      ilv_pkg::PH_FIRST: begin
        if (r.char_in == ilv_pkg::CH_ZERO) begin
          scan_acc = '0;
          scan_ph  = ilv_pkg::PH_ZERO;
        end else begin
          scan_rx = ilv_pkg::RX_DEC;
          scan_ph = ilv_pkg::PH_CONV;
          take_digit(r.char_in);
        end
      end
      ilv_pkg::PH_ZERO: begin
        scan_ph = ilv_pkg::PH_CONV;
        if (r.char_in == ilv_pkg::CH_LX || r.char_in == ilv_pkg::CH_UX) begin
          scan_rx = ilv_pkg::RX_HEX;
        end else if (r.char_in == ilv_pkg::CH_LB) begin
          scan_rx = ilv_pkg::RX_BIN;
        end else if (r.char_in >= ilv_pkg::CH_ZERO && r.char_in <= ilv_pkg::CH_SEVEN) begin
          scan_rx = ilv_pkg::RX_OCT;
          take_digit(r.char_in);
        end else begin
          scan_rx = ilv_pkg::RX_DEC;
          take_digit(r.char_in);
        end
      end
      ilv_pkg::PH_CONV: take_digit(r.char_in);
      default: ;
    endcase
    if (r.last_char) begin
      res.value      = scan_ovf ? '0 : scan_acc[ilv_pkg::VALUE_W-1:0];
      res.overflowed = scan_ovf;
      value_q.push_back(res);
      scan_ph  = ilv_pkg::PH_FIRST;
      scan_rx  = ilv_pkg::RX_DEC;
      scan_acc = '0;
      scan_ovf = 1'b0;
    end
  endtask

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) lit_q.push_back(s[i]);
  endtask

  // Move the literal under construction into the request queue, marking its
  // final character as last.
  task automatic flush_lit();
    ilv_pkg::in_req_t r;
    for (int i = 0; i < lit_q.size(); i++) begin
      r.char_in   = lit_q[i];
      r.last_char = (i == lit_q.size() - 1);
      char_q.push_back(r);
    end
    lit_q.delete();
  endtask

  // Build one random literal: mostly well-formed ones of every base, some
  // right around the signed maximum, plus noise and broken prefixes.
  task automatic gen_literal();
    int    kind;
    int    n;
    string digs;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // Well-formed literal with optional separators and a trailing stop.
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 6);
      case ($urandom_range(0, 3))
        0: begin
          digs = DEC_DIGITS;
          if ($urandom_range(0, 4) == 0) begin
            add_str("0");
            lit_q.push_back(pick_char("89"));
          end else begin
            lit_q.push_back(pick_char("123456789"));
          end
        end
        1: begin
          digs = HEX_DIGITS;
          add_str($urandom_range(0, 1) ? "0x" : "0X");
        end
        2: begin
          digs = OCT_DIGITS;
          add_str("0");
        end
        default: begin
          digs = BIN_DIGITS;
          add_str("0b");
        end
      endcase
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) lit_q.push_back(ilv_pkg::CH_USCORE);
        lit_q.push_back(pick_char(digs));
      end
      if ($urandom_range(0, 4) == 0) begin
        lit_q.push_back(8'($urandom_range(0, 255)));
        lit_q.push_back(pick_char(digs));
      end
    end else if (kind < 70) begin
      // Literals whose value lies just below or just above the signed maximum.
      case ($urandom_range(0, 3))
        0: begin
          add_str("0x");
          lit_q.push_back(pick_char("78"));
          for (int i = 0; i < 15; i++)
            lit_q.push_back($urandom_range(0, 2) ? pick_char("fF") : pick_char(HEX_DIGITS));
        end
        1: begin
          add_str("0");
          lit_q.push_back(pick_char("17"));
          n = $urandom_range(20, 21);
          for (int i = 0; i < n; i++)
            lit_q.push_back($urandom_range(0, 2) ? ilv_pkg::CH_SEVEN : pick_char(OCT_DIGITS));
        end
        2: begin
          add_str("0b");
          n = $urandom_range(62, 64);
          for (int i = 0; i < n; i++)
            lit_q.push_back($urandom_range(0, 3) ? ilv_pkg::CH_ONE : ilv_pkg::CH_ZERO);
        end
        default: begin
          add_str("922337203685477580");
          lit_q.push_back(pick_char(DEC_DIGITS));
          if ($urandom_range(0, 3) == 0) lit_q.push_back(pick_char(DEC_DIGITS));
        end
      endcase
    end else if (kind < 85) begin
      // Noise: arbitrary bytes.
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) lit_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      // Broken sequences: bare prefixes, zero bytes and odd second characters.
      case ($urandom_range(0, 2))
        0: begin
          case ($urandom_range(0, 4))
            0: add_str("0x");
            1: add_str("0X");
            2: add_str("0b");
            3: add_str("0B");
            default: add_str("0");
          endcase
          if ($urandom_range(0, 1)) begin
            lit_q.push_back(NUL_CH);
            lit_q.push_back(pick_char(DEC_DIGITS));
          end
        end
        1: begin
          lit_q.push_back(pick_char(DEC_DIGITS));
          lit_q.push_back(NUL_CH);
          lit_q.push_back(pick_char(DEC_DIGITS));
        end
        default: begin
          add_str("0");
          lit_q.push_back(pick_char("89_zX1"));
          lit_q.push_back(pick_char(HEX_DIGITS));
        end
      endcase
    end
    flush_lit();
  endtask

  // Driver: sends queued requests in bursts with gaps, holding a request
  // while it is stalled, and feeds each accepted request to the scan model.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_req   <= '0;
    end else begin
      if (in_valid && !in_stall) scan_char(in_req);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0 || char_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_req   <= char_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Monitor: stalls on a pattern of changing modes and checks each accepted
  // result against the oldest predicted value.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (value_q.size() == 0) begin
          $error("unexpected result: value=%0h overflowed=%0b",
                 out_res.value, out_res.overflowed);
          err_cnt++;
        end else begin
          want_res = value_q.pop_front();
          if (out_res.value !== want_res.value) begin
            $error("value: expected %0h, got %0h", want_res.value, out_res.value);
            err_cnt++;
          end
          if (out_res.overflowed !== want_res.overflowed) begin
            $error("overflowed: expected %0b, got %0b",
                   want_res.overflowed, out_res.overflowed);
            err_cnt++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(5, 40);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Directed literals: base prefixes, bare prefixes, uppercase "0B", a
    // leading zero before a non-octal digit, separators, a stop character,
    // a zero byte and an all-ones byte.
    add_str("0");     flush_lit();
    add_str("0x");    flush_lit();
    add_str("0b");    flush_lit();
    add_str("0B1");   flush_lit();
    add_str("07");    flush_lit();
    add_str("0_9");   flush_lit();
    add_str("0X_fF"); flush_lit();
    add_str("0b101"); flush_lit();
    add_str("1a2");   flush_lit();
    add_str("0z");    flush_lit();
    add_str("_");     flush_lit();
    add_str("5");
    lit_q.push_back(NUL_CH);
    add_str("7");
    flush_lit();
    lit_q.push_back(8'hFF);
    flush_lit();

    begin : fill_random
      int target;
      target = char_q.size() + RANDOM_ITEMS;
      while (char_q.size() < target) gen_literal();
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (char_q.size() != 0 || in_valid || value_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
